// File: hdl/fsa_pkg.sv
`timescale 1ns / 1ps
// fsa_pkg: sizes, codes and shared types of the free slot allocator.
// No dependencies; every other file of the block but fsa_ram refers to it.

package fsa_pkg;

   localparam int SLOTS    = 16;
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 5;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_FULL         = 3'd1,
      ST_EMPTY_HANDLE = 3'd2,
      ST_BAD_INDEX    = 3'd3,
      ST_NOT_OCCUPIED = 3'd4
   } status_type;

   typedef enum logic {
      STEP_INC = 1'b0,
      STEP_DEC = 1'b1
   } step_op_type;

   typedef struct packed {
      logic [CNT_W-1:0] operand;
      step_op_type      op;
   } step_req_type;

endpackage

// File: hdl/fsa_req_if.sv
`timescale 1ns / 1ps
// fsa_req_if: command channel of the allocator (valid/ready plus command word).
// Depends on fsa_pkg for field widths.

interface fsa_req_if;
   logic                       valid;
   logic                       ready;
   logic [fsa_pkg::CMD_W-1:0]  cmd;
   logic [fsa_pkg::IDX_W-1:0]  slot_index;
   logic                       handle_valid;

   modport source (output valid, cmd, slot_index, handle_valid, input ready);
   modport sink   (input valid, cmd, slot_index, handle_valid, output ready);
endinterface

// File: hdl/fsa_rsp_if.sv
`timescale 1ns / 1ps
// fsa_rsp_if: result channel of the allocator (valid/ready plus result word).
// Depends on fsa_pkg for field widths.

interface fsa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fsa_pkg::IDX_W-1:0]     slot;
   logic [fsa_pkg::STATUS_W-1:0]  status;
   logic [fsa_pkg::CNT_W-1:0]     used_count;
   logic                          is_full;
   logic                          is_empty;

   modport source (output valid, slot, status, used_count, is_full, is_empty, input ready);
   modport sink   (input valid, slot, status, used_count, is_full, is_empty, output ready);
endinterface

// File: hdl/fsa_ram.sv
`timescale 1ns / 1ps
// fsa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module fsa_ram #(
   parameter int DATA_W = 4,
   parameter int DEPTH  = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [DATA_W-1:0]                wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [DATA_W-1:0]                rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/fsa_step.sv
`timescale 1ns / 1ps
// fsa_step: shared increment/decrement unit for the free count and sweep counter.
// Depends on fsa_pkg.

module fsa_step (
   input  fsa_pkg::step_req_type       step_req,
   output logic [fsa_pkg::CNT_W-1:0]   step_result
);

   always_comb begin
      if (step_req.op == fsa_pkg::STEP_DEC) begin
         step_result = step_req.operand - fsa_pkg::CNT_W'(1);
      end else begin
         step_result = step_req.operand + fsa_pkg::CNT_W'(1);
      end
   end

endmodule

// File: hdl/free_slot_allocator.sv
`timescale 1ns / 1ps
// free_slot_allocator: slot pool with a free-index stack in RAM and occupied bits.
// Depends on fsa_pkg, fsa_req_if, fsa_rsp_if, fsa_ram and fsa_step.
//
//   port      dir   word
//   req_chan  in    cmd, slot_index, handle_valid
//   rsp_chan  out   slot, status, used_count, is_full, is_empty
//
// Allocate: S_EXEC, S_ALLOC, S_FINISH (stack read through the RAM's registered
// port). Free, errors, unused command: S_EXEC, S_FINISH. Clear: S_EXEC, S_SWEEP
// (one stack entry rewritten per cycle), S_FINISH. After reset the same sweep
// runs with req_chan.ready low. A result waits in the output register; the next
// word is accepted meanwhile and stalls only when its own result is ready to load.

module free_slot_allocator (
   input  logic      clock,
   input  logic      reset,
   fsa_req_if.sink   req_chan,
   fsa_rsp_if.source rsp_chan
);

   localparam int SLOTS  = fsa_pkg::SLOTS;
   localparam int SLOT_W = fsa_pkg::SLOT_W;
   localparam int CNT_W  = fsa_pkg::CNT_W;
   localparam int IDX_W  = fsa_pkg::IDX_W;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_EXEC,
      S_ALLOC,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   fsa_pkg::cmd_type     cmd_ff, cmd_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 hv_ff, hv_in;
   logic                 from_clear_ff, from_clear_in;
   logic [SLOT_W-1:0]    sweep_ff, sweep_in;
   logic [CNT_W-1:0]     free_count_ff, free_count_in;
   logic [SLOTS-1:0]     occ_ff, occ_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   fsa_pkg::status_type  status_ff, status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_slot_ff, rsp_slot_in;
   fsa_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_used_ff, rsp_used_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   fsa_pkg::step_req_type step_req;
   logic [CNT_W-1:0]      step_result;

   logic                  ram_wr_en;
   logic [SLOT_W-1:0]     ram_wr_addr;
   logic [SLOT_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_data;

   fsa_step u_step (
      .step_req    (step_req),
      .step_result (step_result)
   );

   fsa_ram #(
      .DATA_W (SLOT_W),
      .DEPTH  (SLOTS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (step_result[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.slot       = rsp_slot_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.used_count = rsp_used_ff;
   assign rsp_chan.is_full    = rsp_full_ff;
   assign rsp_chan.is_empty   = rsp_empty_ff;

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      idx_in           = idx_ff;
      hv_in            = hv_ff;
      from_clear_in    = from_clear_ff;
      sweep_in         = sweep_ff;
      free_count_in    = free_count_ff;
      occ_in           = occ_ff;
      slot_in          = slot_ff;
      status_in        = status_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_chan.ready;
      rsp_slot_in      = rsp_slot_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_used_in      = rsp_used_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_empty_in     = rsp_empty_ff;
      step_req.operand = free_count_ff;
      step_req.op      = fsa_pkg::STEP_INC;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = sweep_ff;
      ram_wr_data      = sweep_ff;
      ram_rd_en        = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            // rewrite stack to identity order
            step_req.operand = CNT_W'(sweep_ff);
            ram_wr_en        = 1'b1;
            sweep_in         = step_result[SLOT_W-1:0];
            if (sweep_ff == SLOT_W'(SLOTS - 1)) begin
               free_count_in = CNT_W'(SLOTS);
               state_in      = from_clear_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = fsa_pkg::cmd_type'(req_chan.cmd);
               idx_in   = req_chan.slot_index;
               hv_in    = req_chan.handle_valid;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            slot_in   = IDX_W'(SLOTS);
            status_in = fsa_pkg::ST_OK;
            state_in  = S_FINISH;
            unique case (cmd_ff)
               fsa_pkg::CMD_ALLOC: begin
                  if (free_count_ff == '0) begin
                     status_in = fsa_pkg::ST_FULL;
                  end else begin
                     step_req.op = fsa_pkg::STEP_DEC;
                     ram_rd_en   = 1'b1;
                     state_in    = S_ALLOC;
                  end
               end
               fsa_pkg::CMD_FREE: begin
                  if (!hv_ff) begin
                     status_in = fsa_pkg::ST_EMPTY_HANDLE;
                  end else if (idx_ff >= IDX_W'(SLOTS)) begin
                     status_in = fsa_pkg::ST_BAD_INDEX;
                  end else if (!occ_ff[idx_ff[SLOT_W-1:0]]) begin
                     status_in = fsa_pkg::ST_NOT_OCCUPIED;
                  end else begin
                     // occupied slot implies free_count below SLOTS
                     ram_wr_en                  = 1'b1;
                     ram_wr_addr                = free_count_ff[SLOT_W-1:0];
                     ram_wr_data                = idx_ff[SLOT_W-1:0];
                     occ_in[idx_ff[SLOT_W-1:0]] = 1'b0;
                     free_count_in              = step_result;
                  end
               end
               fsa_pkg::CMD_CLEAR: begin
                  occ_in        = '0;
                  sweep_in      = '0;
                  from_clear_in = 1'b1;
                  state_in      = S_SWEEP;
               end
               default: begin
               end
            endcase
         end
         S_ALLOC: begin
            step_req.op         = fsa_pkg::STEP_DEC;
            free_count_in       = step_result;
            occ_in[ram_rd_data] = 1'b1;
            slot_in             = IDX_W'(ram_rd_data);
            state_in            = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = slot_ff;
               rsp_status_in = status_ff;
               rsp_used_in   = CNT_W'(SLOTS) - free_count_ff;
               rsp_full_in   = (free_count_ff == '0);
               rsp_empty_in  = (free_count_ff == CNT_W'(SLOTS));
               from_clear_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      hv_ff         <= hv_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_empty_ff  <= rsp_empty_in;
      if (reset) begin
         state_ff      <= S_SWEEP;
         from_clear_ff <= 1'b0;
         sweep_ff      <= '0;
         free_count_ff <= CNT_W'(SLOTS);
         occ_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         from_clear_ff <= from_clear_in;
         sweep_ff      <= sweep_in;
         free_count_ff <= free_count_in;
         occ_ff        <= occ_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// File: bench/fsa_result_checker.sv
`timescale 1ns / 1ps
// fsa_result_checker: watches the command and result channels of the allocator and
// keeps its own slot pool to predict every result, compared in order of arrival.
// Depends on fsa_pkg, fsa_req_if and fsa_rsp_if.

module fsa_result_checker (
   input  logic clock,
   input  logic reset,
   fsa_req_if   req_bus,
   fsa_rsp_if   rsp_bus,
   output int   mismatch_count,
   output int   pending_count
);

   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [fsa_pkg::IDX_W-1:0] slot;
      fsa_pkg::status_type       status;
      logic [fsa_pkg::CNT_W-1:0] used_count;
      logic                      is_full;
      logic                      is_empty;
   } alloc_result_type;

   logic [fsa_pkg::SLOT_W-1:0] free_stack [fsa_pkg::SLOTS];
   logic [fsa_pkg::SLOTS-1:0]  occupied;
   int                         free_cnt;
   alloc_result_type           pending_results [$];
   int                         errors = 0;

   task automatic restore_pool();
      for (int i = 0; i < fsa_pkg::SLOTS; i++) free_stack[i] = fsa_pkg::SLOT_W'(i);
      occupied = '0;
      free_cnt = fsa_pkg::SLOTS;
   endtask

   task automatic apply_command(input logic [fsa_pkg::CMD_W-1:0] cmd,
                                input logic [fsa_pkg::IDX_W-1:0] idx,
                                input logic hv, output alloc_result_type res);
      res.slot   = fsa_pkg::IDX_W'(fsa_pkg::SLOTS);
      res.status = fsa_pkg::ST_OK;
      case (cmd)
         fsa_pkg::CMD_ALLOC: begin
            if (free_cnt == 0) begin
               res.status = fsa_pkg::ST_FULL;
            end else begin
               free_cnt--;
               res.slot = fsa_pkg::IDX_W'(free_stack[fsa_pkg::SLOT_W'(free_cnt)]);
               occupied[free_stack[fsa_pkg::SLOT_W'(free_cnt)]] = 1'b1;
            end
         end
         fsa_pkg::CMD_FREE: begin
            if (!hv) res.status = fsa_pkg::ST_EMPTY_HANDLE;
            else if (idx >= fsa_pkg::SLOTS) res.status = fsa_pkg::ST_BAD_INDEX;
            else if (!occupied[idx[fsa_pkg::SLOT_W-1:0]]) res.status = fsa_pkg::ST_NOT_OCCUPIED;
            else begin
               occupied[idx[fsa_pkg::SLOT_W-1:0]] = 1'b0;
               free_stack[fsa_pkg::SLOT_W'(free_cnt)] = idx[fsa_pkg::SLOT_W-1:0];
               free_cnt++;
            end
         end
         fsa_pkg::CMD_CLEAR: restore_pool();
         default: ;
      endcase
      res.used_count = fsa_pkg::CNT_W'(fsa_pkg::SLOTS - free_cnt);
      res.is_full    = (free_cnt == 0);
      res.is_empty   = (free_cnt == fsa_pkg::SLOTS);
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         restore_pool();
         pending_results.delete();
         errors = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("%0t: unexpected result word slot %0d status %0d used %0d",
                           $time, rsp_bus.slot, rsp_bus.status, rsp_bus.used_count);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.slot !== want.slot || rsp_bus.status !== want.status ||
                   rsp_bus.used_count !== want.used_count ||
                   rsp_bus.is_full !== want.is_full || rsp_bus.is_empty !== want.is_empty) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("%0t: expected slot %0d status %0d used %0d full %0b empty %0b",
                              $time, want.slot, want.status, want.used_count,
                              want.is_full, want.is_empty);
                     $display("          got slot %0d status %0d used %0d full %0b empty %0b",
                              rsp_bus.slot, rsp_bus.status, rsp_bus.used_count,
                              rsp_bus.is_full, rsp_bus.is_empty);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            apply_command(req_bus.cmd, req_bus.slot_index, req_bus.handle_valid, want);
            pending_results.push_back(want);
         end
      end
      mismatch_count <= errors;
      pending_count  <= pending_results.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives command words into free_slot_allocator under varying back-pressure
// and reports the verdict. Depends on fsa_pkg, the channel interfaces and fsa_result_checker.

module tb_top;

   localparam int ITEMS       = 1500;
   localparam int PHASE_LEN   = 500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 400;
   localparam logic [fsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   pending;
   int   cycles = 0;
   int   words_sent = 0;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   fsa_req_if req_bus ();
   fsa_rsp_if rsp_bus ();

   free_slot_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   fsa_result_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off so the input backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else if (!hold_done && words_sent >= HOLD_AT) begin
         hold_done     = 1'b1;
         hold_left     = HOLD_CYCLES;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // called just after a falling edge; returns just after the falling edge that
   // follows acceptance, with valid still high
   task automatic send_word(input logic [fsa_pkg::CMD_W-1:0] cmd,
                            input logic [fsa_pkg::IDX_W-1:0] idx,
                            input logic hv);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.cmd          = cmd;
      req_bus.slot_index   = idx;
      req_bus.handle_valid = hv;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   initial begin
      int                        counted;
      int                        alloc_pct;
      int                        pick;
      logic [fsa_pkg::CMD_W-1:0] cmd;
      logic [fsa_pkg::IDX_W-1:0] idx;
      logic                      hv;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = fsa_pkg::CMD_ALLOC;
      req_bus.slot_index   = '0;
      req_bus.handle_valid = 1'b0;
      req_idle_pct         = 34;
      rsp_idle_pct         = 66;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(fsa_pkg::CMD_FREE, 5'd0, 1'b1);            // nothing occupied yet
      send_word(fsa_pkg::CMD_FREE, 5'd31, 1'b0);           // empty handle wins over bad index
      send_word(fsa_pkg::CMD_FREE, fsa_pkg::IDX_W'(fsa_pkg::SLOTS), 1'b1);
      send_word(fsa_pkg::CMD_FREE, 5'd31, 1'b1);
      send_word(CMD_UNUSED, 5'd21, 1'b1);
      repeat (fsa_pkg::SLOTS) send_word(fsa_pkg::CMD_ALLOC, '0, 1'b0);
      send_word(fsa_pkg::CMD_ALLOC, 5'd31, 1'b1);          // pool full
      send_word(fsa_pkg::CMD_FREE, 5'd15, 1'b1);
      send_word(fsa_pkg::CMD_FREE, 5'd0, 1'b1);
      send_word(fsa_pkg::CMD_FREE, 5'd0, 1'b1);            // double free
      send_word(fsa_pkg::CMD_CLEAR, 5'd31, 1'b1);

      counted   = 0;
      alloc_pct = 50;
      while (counted < ITEMS) begin
         if (counted < PHASE_LEN) begin
            req_idle_pct = 34;
            rsp_idle_pct = 66;
         end else if (counted < 2 * PHASE_LEN) begin
            req_idle_pct = 66;
            rsp_idle_pct = 34;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (counted % 40 == 0) begin
            case ($urandom_range(2))
               0: alloc_pct = 20;
               1: alloc_pct = 50;
               default: alloc_pct = 85;
            endcase
         end
         pick = $urandom_range(99);
         idx  = fsa_pkg::IDX_W'($urandom);
         hv   = 1'($urandom);
         if (pick < 2) begin
            cmd = fsa_pkg::CMD_CLEAR;
         end else if (pick < 5) begin
            cmd = CMD_UNUSED;
         end else if (pick < 8) begin
            cmd = fsa_pkg::CMD_FREE;
            hv  = 1'b0;
         end else if (pick < 11) begin
            cmd = fsa_pkg::CMD_FREE;
            idx = fsa_pkg::IDX_W'($urandom_range(fsa_pkg::SLOTS, 31));
            hv  = 1'b1;
         end else if ($urandom_range(99) < alloc_pct) begin
            cmd = fsa_pkg::CMD_ALLOC;
         end else begin
            cmd = fsa_pkg::CMD_FREE;
            idx = fsa_pkg::IDX_W'($urandom_range(fsa_pkg::SLOTS - 1));
            hv  = 1'b1;
         end
         send_word(cmd, idx, hv);
         if (cmd != CMD_UNUSED) counted++;
      end

      req_bus.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (fsa_pkg::SLOTS + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
